>>> hdl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and constants of the led blink pattern sequencer
// Operation and mode codes, and the widths of the stream words.
// ----------------------------------------------------------------------------
`default_nettype none

package lbps_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_MODE = 2'd1,
        OP_WRITE    = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    // pin modes
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_ONCE  = 2'd3
    } t_mode;

    // field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned DUR_W   = 16;

    // number of addressable entries, fixed by the entry index width
    localparam int unsigned INDEX_SPAN = 1 << INDEX_W;

    // stream word widths, padded to whole bytes
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 8;

endpackage : lbps_pkg

`default_nettype wire

>>> hdl/led_blink_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer: one-pin blink pattern sequencer
// Tick, mode-set and pattern-write words update the sequencer state and each
// word returns the pin level and mode that hold after it.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while the output keeps up and returns one
// result word per input word, offered from the output register and held until
// the output side takes it. A word is held in an input register, the state
// update (pattern store reads, a 16-bit decrement and compares) runs in that
// cycle, and the result is held in an output register; with the output stalled
// the input register absorbs one more word before o_s_axis_tready drops. The
// pattern store sits in flip-flops that reset clears at once, so the block is
// ready right after reset. Entries past the stored range are never read; the
// pattern ends there or at the first zero entry.
`default_nettype none

module led_blink_pattern_sequencer
    import lbps_pkg::*;
#(
    parameter int unsigned PATTERN_LEN = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input words
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // new_mode [1:0], entry_index [6:2], entry_duration [22:7], zero [23]
    input  wire  [IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation [1:0]
    input  wire  [OP_W-1:0]       i_s_axis_tuser,
    // result words
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // pin_level [0], current_mode [2:1], zero [7:3]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // only the writable part of the pattern is stored
    localparam int unsigned STORE_DEPTH =
        (PATTERN_LEN < INDEX_SPAN) ? PATTERN_LEN : INDEX_SPAN;
    localparam int unsigned POS_W = $clog2(STORE_DEPTH);

    // input register
    logic                 r_in_vld;
    t_op                  r_in_op;
    t_mode                r_in_mode;
    logic [INDEX_W-1:0]   r_in_idx;
    logic [DUR_W-1:0]     r_in_dur;

    // sequencer state
    t_mode                r_mode,  n_mode;
    logic [POS_W-1:0]     r_pos,   n_pos;
    logic [DUR_W-1:0]     r_left,  n_left;
    logic [DUR_W-1:0]     r_store [STORE_DEPTH];

    // result register
    logic                 r_out_vld;
    logic                 r_out_level, n_level;
    t_mode                r_out_mode;

    logic                 adv;
    logic                 wr_en;
    logic [POS_W:0]       step_next;
    logic [DUR_W-1:0]     step_dur;
    logic                 step_end;
    logic [DUR_W-1:0]     left_dec;

    // handshake: the stage moves when the result register is free or drains
    assign adv             = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= t_op'(i_s_axis_tuser);
            r_in_mode <= t_mode'(i_s_axis_tdata[MODE_W-1:0]);
            r_in_idx  <= i_s_axis_tdata[MODE_W +: INDEX_W];
            r_in_dur  <= i_s_axis_tdata[MODE_W+INDEX_W +: DUR_W];
        end
    end

    // next position and its duration, end of list on zero or end of store
    assign step_next = {1'b0, r_pos} + {{POS_W{1'b0}}, 1'b1};
    assign step_dur  = r_store[step_next[POS_W-1:0]];
    assign step_end  = (32'(step_next) >= STORE_DEPTH) || (step_dur == '0);
    assign left_dec  = (r_left != '0) ? (r_left - DUR_W'(1)) : r_left;

    // pattern write, ignored past the pattern length
    assign wr_en = adv && (r_in_op == OP_WRITE) && (32'(r_in_idx) < PATTERN_LEN);

    // state update for the word in the input register
    always_comb begin
        n_mode = r_mode;
        n_pos  = r_pos;
        n_left = r_left;
        case (r_in_op)
            OP_TICK: begin
                if (r_mode == MODE_BLINK || r_mode == MODE_ONCE) begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        if (step_end) begin
                            n_pos  = '0;
                            n_left = r_store[0];
                            if (r_mode == MODE_ONCE) begin
                                n_mode = MODE_OFF;
                            end
                        end else begin
                            n_pos  = step_next[POS_W-1:0];
                            n_left = step_dur;
                        end
                    end
                end
            end
            OP_SET_MODE: begin
                if (r_in_mode != r_mode) begin
                    n_mode = r_in_mode;
                    if (r_in_mode == MODE_BLINK || r_in_mode == MODE_ONCE) begin
                        n_pos  = '0;
                        n_left = r_store[0];
                    end
                end
            end
            OP_WRITE: begin
                if (32'(r_in_idx) < PATTERN_LEN) begin
                    n_pos = '0;
                end
            end
            default: begin
            end
        endcase

        // pin level from the updated state
        case (n_mode)
            MODE_ON:    n_level = 1'b1;
            MODE_BLINK: n_level = ~n_pos[0];
            MODE_ONCE:  n_level = ~n_pos[0];
            default:    n_level = 1'b0;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
            r_pos  <= '0;
            r_left <= '0;
        end else if (adv) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

    // pattern store, empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (wr_en) begin
            r_store[r_in_idx[POS_W-1:0]] <= r_in_dur;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_level <= n_level;
            r_out_mode  <= n_mode;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-MODE_W-1){1'b0}}, r_out_mode, r_out_level};

    // checks

    // position stays inside the stored pattern
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < STORE_DEPTH)
        else $error("step position beyond pattern store");

    // a word in the input register is not lost while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("input word dropped during stall");

    // off and on modes drive fixed levels
    a_fixed_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_mode == MODE_OFF || r_out_mode == MODE_ON)
        |-> (r_out_level == (r_out_mode == MODE_ON)))
        else $error("pin level does not match fixed mode");

    // result state matches the sequencer state it was taken from
    a_out_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_out_mode == r_mode))
        else $error("result mode differs from sequencer mode");

endmodule : led_blink_pattern_sequencer

`default_nettype wire
